@@ rtl/tnaa_pkg.sv @@
// tnaa_pkg: widths and codes shared by the triangle normal and area pipeline.
// No dependencies.
package tnaa_pkg;

    localparam int IDX_W   = 12;
    localparam int COORD_W = 24;
    localparam int VTX_W   = 3 * COORD_W;
    localparam int EDGE_W  = COORD_W + 1;
    localparam int PROD_W  = 2 * EDGE_W;
    localparam int CROSS_W = PROD_W + 1;
    localparam int MAG_W   = 50;
    localparam int HALF_W  = MAG_W / 2;
    localparam int SQ_W    = 2 * MAG_W;
    localparam int SUM_W   = SQ_W + 2;
    localparam int ROOT_W  = 52;
    localparam int FRAC_SH = 31;
    localparam int NUM_W   = MAG_W + FRAC_SH + 1;
    localparam int Q_W     = 31;
    localparam int NRM_W   = 32;
    localparam int AREA_W  = 51;

    localparam logic OP_LOAD = 1'b0;
    localparam logic OP_FACE = 1'b1;

    typedef logic [2:0][MAG_W-1:0] mag3_t;
    typedef logic [2:0][Q_W-1:0]   quot3_t;

endpackage

@@ rtl/tnaa_ram.sv @@
// tnaa_ram: generic single-write, single-read RAM with registered read data.
// No dependencies.
module tnaa_ram #(
    parameter int WIDTH = 72,
    parameter int DEPTH = 4096
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

@@ rtl/tnaa_cross.sv @@
// tnaa_cross: edges, cross product, magnitudes and sum of squares, seven stages.
// Depends on tnaa_pkg.
module tnaa_cross (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      en,
    input  logic                      in_valid,
    input  logic [tnaa_pkg::VTX_W-1:0] v0,
    input  logic [tnaa_pkg::VTX_W-1:0] v1,
    input  logic [tnaa_pkg::VTX_W-1:0] v2,
    output logic                      out_valid,
    output tnaa_pkg::mag3_t           mag,
    output logic [2:0]                sign,
    output logic [tnaa_pkg::SUM_W-1:0] sum
);
    import tnaa_pkg::*;

    logic [6:0] vld_reg, vld_next;

    logic signed [EDGE_W-1:0]  e1_reg [3], e2_reg [3], e1_next [3], e2_next [3];
    logic signed [PROD_W-1:0]  p_reg [6], p_next [6];
    logic signed [CROSS_W-1:0] c_reg [3], c_next [3];
    mag3_t                     m5_reg, m5_next, m6_reg, m7_reg, m8_reg;
    logic [2:0]                s5_reg, s5_next, s6_reg, s7_reg, s8_reg;
    logic [PROD_W-1:0]         hh_reg [3], hl_reg [3], ll_reg [3];
    logic [PROD_W-1:0]         hh_next [3], hl_next [3], ll_next [3];
    logic [SQ_W-1:0]           sq_reg [3], sq_next [3];
    logic [SUM_W-1:0]          sum_reg, sum_next;

    assign vld_next = {vld_reg[5:0], in_valid};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else if (en)
        begin
            vld_reg <= vld_next;
        end
    end

    always_comb
    begin
        for (int k = 0; k < 3; k++)
        begin
            e1_next[k] = EDGE_W'($signed(v1[k*COORD_W +: COORD_W]))
                       - EDGE_W'($signed(v0[k*COORD_W +: COORD_W]));
            e2_next[k] = EDGE_W'($signed(v2[k*COORD_W +: COORD_W]))
                       - EDGE_W'($signed(v0[k*COORD_W +: COORD_W]));
        end
        p_next[0] = e1_reg[1] * e2_reg[2];
        p_next[1] = e1_reg[2] * e2_reg[1];
        p_next[2] = e1_reg[2] * e2_reg[0];
        p_next[3] = e1_reg[0] * e2_reg[2];
        p_next[4] = e1_reg[0] * e2_reg[1];
        p_next[5] = e1_reg[1] * e2_reg[0];
        for (int k = 0; k < 3; k++)
        begin
            c_next[k]  = CROSS_W'(p_reg[2*k]) - CROSS_W'(p_reg[2*k+1]);
            s5_next[k] = c_reg[k][CROSS_W-1];
            m5_next[k] = c_reg[k][CROSS_W-1] ? MAG_W'(-c_reg[k]) : MAG_W'(c_reg[k]);
            hh_next[k] = m5_reg[k][MAG_W-1:HALF_W] * m5_reg[k][MAG_W-1:HALF_W];
            hl_next[k] = m5_reg[k][MAG_W-1:HALF_W] * m5_reg[k][HALF_W-1:0];
            ll_next[k] = m5_reg[k][HALF_W-1:0] * m5_reg[k][HALF_W-1:0];
            sq_next[k] = (SQ_W'(hh_reg[k]) << (2 * HALF_W))
                       + (SQ_W'(hl_reg[k]) << (HALF_W + 1))
                       + SQ_W'(ll_reg[k]);
        end
        sum_next = SUM_W'(sq_reg[0]) + SUM_W'(sq_reg[1]) + SUM_W'(sq_reg[2]);
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            e1_reg  <= e1_next;
            e2_reg  <= e2_next;
            p_reg   <= p_next;
            c_reg   <= c_next;
            m5_reg  <= m5_next;
            s5_reg  <= s5_next;
            hh_reg  <= hh_next;
            hl_reg  <= hl_next;
            ll_reg  <= ll_next;
            m6_reg  <= m5_reg;
            s6_reg  <= s5_reg;
            sq_reg  <= sq_next;
            m7_reg  <= m6_reg;
            s7_reg  <= s6_reg;
            sum_reg <= sum_next;
            m8_reg  <= m7_reg;
            s8_reg  <= s7_reg;
        end
    end

    assign out_valid = vld_reg[6];
    assign mag       = m8_reg;
    assign sign      = s8_reg;
    assign sum       = sum_reg;

endmodule

@@ rtl/tnaa_sqrt.sv @@
// tnaa_sqrt: pipelined integer square root, one root bit per stage.
// Depends on tnaa_pkg.
module tnaa_sqrt (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        en,
    input  logic                        in_valid,
    input  logic [tnaa_pkg::SUM_W-1:0]  sum,
    input  tnaa_pkg::mag3_t             mag_in,
    input  logic [2:0]                  sign_in,
    output logic                        out_valid,
    output logic [tnaa_pkg::ROOT_W-1:0] root,
    output tnaa_pkg::mag3_t             mag_out,
    output logic [2:0]                  sign_out
);
    import tnaa_pkg::*;

    logic [ROOT_W-1:0] vld_reg, vld_next;
    logic [SUM_W-1:0]  rem_reg  [ROOT_W];
    logic [ROOT_W-1:0] root_reg [ROOT_W];
    mag3_t             mag_reg  [ROOT_W];
    logic [2:0]        sign_reg [ROOT_W];

    assign vld_next = {vld_reg[ROOT_W-2:0], in_valid};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else if (en)
        begin
            vld_reg <= vld_next;
        end
    end

    for (genvar s = 0; s < ROOT_W; s++)
    begin : g_stage
        localparam int B = ROOT_W - 1 - s;
        logic [SUM_W-1:0]  rem_in, rem_next;
        logic [ROOT_W-1:0] root_in, root_next;
        mag3_t             mag_st;
        logic [2:0]        sign_st;
        logic [SUM_W+1:0]  trial;
        logic              take;

        if (s == 0)
        begin : g_first
            assign rem_in  = sum;
            assign root_in = '0;
            assign mag_st  = mag_in;
            assign sign_st = sign_in;
        end
        else
        begin : g_rest
            assign rem_in  = rem_reg[s-1];
            assign root_in = root_reg[s-1];
            assign mag_st  = mag_reg[s-1];
            assign sign_st = sign_reg[s-1];
        end

        always_comb
        begin
            trial     = ((SUM_W+2)'(root_in) << (B + 1)) | ((SUM_W+2)'(1) << (2 * B));
            take      = {2'b00, rem_in} >= trial;
            rem_next  = take ? rem_in - trial[SUM_W-1:0] : rem_in;
            root_next = take ? root_in | (ROOT_W'(1) << B) : root_in;
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                rem_reg[s]  <= rem_next;
                root_reg[s] <= root_next;
                mag_reg[s]  <= mag_st;
                sign_reg[s] <= sign_st;
            end
        end
    end

    assign out_valid = vld_reg[ROOT_W-1];
    assign root      = root_reg[ROOT_W-1];
    assign mag_out   = mag_reg[ROOT_W-1];
    assign sign_out  = sign_reg[ROOT_W-1];

endmodule

@@ rtl/tnaa_div.sv @@
// tnaa_div: pipelined rounded division of three magnitudes by the norm,
// one quotient bit per stage after a setup stage. Depends on tnaa_pkg.
module tnaa_div (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        en,
    input  logic                        in_valid,
    input  logic [tnaa_pkg::ROOT_W-1:0] root_in,
    input  tnaa_pkg::mag3_t             mag_in,
    input  logic [2:0]                  sign_in,
    output logic                        out_valid,
    output logic [tnaa_pkg::ROOT_W-1:0] root_out,
    output tnaa_pkg::quot3_t            quot,
    output logic [2:0]                  sign_out
);
    import tnaa_pkg::*;

    logic [Q_W:0]      vld_reg, vld_next;
    logic [NUM_W-1:0]  num_reg [3], num_next [3];
    logic [ROOT_W-1:0] r0_reg;
    logic [2:0]        s0_reg;
    logic [NUM_W-1:0]  rem_reg  [Q_W][3];
    quot3_t            q_reg    [Q_W];
    logic [ROOT_W-1:0] root_reg [Q_W];
    logic [2:0]        sign_reg [Q_W];

    assign vld_next = {vld_reg[Q_W-1:0], in_valid};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else if (en)
        begin
            vld_reg <= vld_next;
        end
    end

    always_comb
    begin
        for (int k = 0; k < 3; k++)
        begin
            num_next[k] = (NUM_W'(mag_in[k]) << FRAC_SH) + NUM_W'(root_in);
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            num_reg <= num_next;
            r0_reg  <= root_in;
            s0_reg  <= sign_in;
        end
    end

    for (genvar s = 0; s < Q_W; s++)
    begin : g_stage
        localparam int I = Q_W - 1 - s;
        logic [NUM_W-1:0]  rem_in [3];
        logic [NUM_W-1:0]  rem_next [3];
        quot3_t            q_in, q_next;
        logic [ROOT_W-1:0] root_st;
        logic [2:0]        sign_st;
        logic [NUM_W+1:0]  trial;

        if (s == 0)
        begin : g_first
            assign rem_in  = num_reg;
            assign q_in    = '0;
            assign root_st = r0_reg;
            assign sign_st = s0_reg;
        end
        else
        begin : g_rest
            assign rem_in  = rem_reg[s-1];
            assign q_in    = q_reg[s-1];
            assign root_st = root_reg[s-1];
            assign sign_st = sign_reg[s-1];
        end

        always_comb
        begin
            trial  = (NUM_W+2)'(root_st) << (I + 1);
            q_next = q_in;
            for (int k = 0; k < 3; k++)
            begin
                if ({2'b00, rem_in[k]} >= trial)
                begin
                    rem_next[k] = rem_in[k] - trial[NUM_W-1:0];
                    q_next[k]   = q_in[k] | (Q_W'(1) << I);
                end
                else
                begin
                    rem_next[k] = rem_in[k];
                end
            end
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                rem_reg[s]  <= rem_next;
                q_reg[s]    <= q_next;
                root_reg[s] <= root_st;
                sign_reg[s] <= sign_st;
            end
        end
    end

    assign out_valid = vld_reg[Q_W];
    assign root_out  = root_reg[Q_W-1];
    assign quot      = q_reg[Q_W-1];
    assign sign_out  = sign_reg[Q_W-1];

endmodule

@@ rtl/triangle_normal_and_area.sv @@
// triangle_normal_and_area: vertex store plus face unit normal and area pipeline.
// Depends on tnaa_pkg, tnaa_ram, tnaa_cross, tnaa_sqrt, tnaa_div.
//
// Input channel (in_valid/in_ready): opcode 0 writes coord_x/y/z into vertex_slot
// and gives no result; a slot at or above VERTEX_COUNT is dropped. Opcode 1 reads
// corners corner_first/second/third (an index past the store reads as zero) and
// gives one result on the output channel (out_valid/out_ready): unit normal in
// Q1.30, face_area as an unsigned integer, half the floored norm of the edge
// cross product, and degenerate with zeros when the edges are parallel.
// Pipeline: a face result passes through one store read, seven stages of cross
// product and squares, 52 square root stages (one root bit each), one setup
// and 31 divide stages, and one output stage.
// Throughput: one item per cycle unless stalled; a load written in one cycle is
// seen by a face accepted in the next. The pipeline advances as a whole whenever
// the output register is empty or being taken, so in_ready drops only while a
// result waits and out_ready is low; nothing is lost or repeated across a stall.
// Reset clears all valid bits; the vertex store is not cleared and a vertex must
// be loaded before a face reads it.
module triangle_normal_and_area #(
    parameter int VERTEX_COUNT = 4096
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic                          opcode,
    input  logic [tnaa_pkg::IDX_W-1:0]    vertex_slot,
    input  logic signed [tnaa_pkg::COORD_W-1:0] coord_x,
    input  logic signed [tnaa_pkg::COORD_W-1:0] coord_y,
    input  logic signed [tnaa_pkg::COORD_W-1:0] coord_z,
    input  logic [tnaa_pkg::IDX_W-1:0]    corner_first,
    input  logic [tnaa_pkg::IDX_W-1:0]    corner_second,
    input  logic [tnaa_pkg::IDX_W-1:0]    corner_third,
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic signed [tnaa_pkg::NRM_W-1:0] normal_x,
    output logic signed [tnaa_pkg::NRM_W-1:0] normal_y,
    output logic signed [tnaa_pkg::NRM_W-1:0] normal_z,
    output logic [tnaa_pkg::AREA_W-1:0]   face_area,
    output logic                          degenerate
);
    import tnaa_pkg::*;

    localparam int AW = $clog2(VERTEX_COUNT);

    logic          en, accept, we;
    logic [31:0]   slot_w, idx_w [3];
    logic [AW-1:0] raddr [3];
    logic [2:0]    oob;
    logic [2:0]    oob_reg;
    logic          v1_reg, v1_next;
    logic [VTX_W-1:0] rdata [3], vtx [3];

    logic              cr_valid, sq_valid, dv_valid;
    mag3_t             cr_mag, sq_mag;
    logic [2:0]        cr_sign, sq_sign, dv_sign;
    logic [SUM_W-1:0]  cr_sum;
    logic [ROOT_W-1:0] sq_root, dv_root;
    quot3_t            dv_quot;

    logic                    out_valid_reg, out_valid_next;
    logic [NRM_W-1:0]        nrm_reg [3], nrm_next [3];
    logic [AREA_W-1:0]       area_reg, area_next;
    logic                    degen_reg, degen_next;

    assign en       = !out_valid_reg || out_ready;
    assign in_ready = en;
    assign accept   = in_valid && en;
    assign slot_w   = 32'(vertex_slot);
    assign we       = accept && (opcode == OP_LOAD) && (slot_w < 32'(VERTEX_COUNT));
    assign idx_w[0] = 32'(corner_first);
    assign idx_w[1] = 32'(corner_second);
    assign idx_w[2] = 32'(corner_third);
    assign v1_next  = accept && (opcode == OP_FACE);

    for (genvar g = 0; g < 3; g++)
    begin : g_store
        assign raddr[g] = idx_w[g][AW-1:0];
        assign oob[g]   = idx_w[g] >= 32'(VERTEX_COUNT);
        assign vtx[g]   = oob_reg[g] ? '0 : rdata[g];

        tnaa_ram #(
            .WIDTH(VTX_W),
            .DEPTH(VERTEX_COUNT)
        ) u_ram (
            .clk  (clk),
            .we   (we),
            .waddr(slot_w[AW-1:0]),
            .wdata({coord_z, coord_y, coord_x}),
            .re   (en),
            .raddr(raddr[g]),
            .rdata(rdata[g])
        );
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg        <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (en)
            begin
                v1_reg <= v1_next;
            end
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            oob_reg   <= oob;
            nrm_reg   <= nrm_next;
            area_reg  <= area_next;
            degen_reg <= degen_next;
        end
    end

    tnaa_cross u_cross (
        .clk      (clk),
        .rst_n    (rst_n),
        .en       (en),
        .in_valid (v1_reg),
        .v0       (vtx[0]),
        .v1       (vtx[1]),
        .v2       (vtx[2]),
        .out_valid(cr_valid),
        .mag      (cr_mag),
        .sign     (cr_sign),
        .sum      (cr_sum)
    );

    tnaa_sqrt u_sqrt (
        .clk      (clk),
        .rst_n    (rst_n),
        .en       (en),
        .in_valid (cr_valid),
        .sum      (cr_sum),
        .mag_in   (cr_mag),
        .sign_in  (cr_sign),
        .out_valid(sq_valid),
        .root     (sq_root),
        .mag_out  (sq_mag),
        .sign_out (sq_sign)
    );

    tnaa_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .en       (en),
        .in_valid (sq_valid),
        .root_in  (sq_root),
        .mag_in   (sq_mag),
        .sign_in  (sq_sign),
        .out_valid(dv_valid),
        .root_out (dv_root),
        .quot     (dv_quot),
        .sign_out (dv_sign)
    );

    always_comb
    begin
        out_valid_next = en ? dv_valid : out_valid_reg;
        degen_next     = dv_root == '0;
        area_next      = degen_next ? '0 : dv_root[AREA_W:1];
        for (int k = 0; k < 3; k++)
        begin
            if (degen_next)
            begin
                nrm_next[k] = '0;
            end
            else if (dv_sign[k])
            begin
                nrm_next[k] = -NRM_W'(dv_quot[k]);
            end
            else
            begin
                nrm_next[k] = NRM_W'(dv_quot[k]);
            end
        end
    end

    assign out_valid  = out_valid_reg;
    assign normal_x   = nrm_reg[0];
    assign normal_y   = nrm_reg[1];
    assign normal_z   = nrm_reg[2];
    assign face_area  = area_reg;
    assign degenerate = degen_reg;

endmodule

@@ rtl/tnaa_check.sv @@
// tnaa_check: port-level assertions for triangle_normal_and_area, bound to it.
// Depends on tnaa_pkg.
module tnaa_check (
    input logic                          clk,
    input logic                          rst_n,
    input logic                          in_valid,
    input logic                          in_ready,
    input logic                          out_valid,
    input logic                          out_ready,
    input logic signed [tnaa_pkg::NRM_W-1:0] normal_x,
    input logic signed [tnaa_pkg::NRM_W-1:0] normal_y,
    input logic signed [tnaa_pkg::NRM_W-1:0] normal_z,
    input logic [tnaa_pkg::AREA_W-1:0]   face_area,
    input logic                          degenerate
);
    import tnaa_pkg::*;

    localparam logic signed [NRM_W-1:0] ONE = 32'sd1073741824;

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(normal_x) && $stable(normal_y)
            && $stable(normal_z) && $stable(face_area) && $stable(degenerate))
        else $error("result changed while stalled");

    a_stall_blocks: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |-> !in_ready)
        else $error("item taken while pipeline stalled");

    a_degen_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && degenerate |-> normal_x == '0 && normal_y == '0
            && normal_z == '0 && face_area == '0)
        else $error("degenerate face with nonzero fields");

    a_unit_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !degenerate |-> normal_x <= ONE && normal_x >= -ONE
            && normal_y <= ONE && normal_y >= -ONE && normal_z <= ONE && normal_z >= -ONE)
        else $error("normal out of unit range");

endmodule

bind triangle_normal_and_area tnaa_check u_tnaa_check (.*);
